[src/dq_pkg.sv]
// Shared constants, operation codes and status codes for the double-ended queue.
package dq_pkg;

  localparam int DQ_DEPTH     = 16;
  localparam int KIND_W       = 3;
  localparam int WORD_W       = 32;
  localparam int STATUS_W     = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LIST       = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

[src/double_ended_queue.sv]
// Bounded double-ended queue of 32-bit words on a circular single-port-read store.
// A push result is registered from the accepted item; pop and list words first pass rd_q.
// Throughput: push one item per cycle while the output is free; a pop finishes before the
// next item is taken; list gives one stored word per cycle while the output is free.
// Reset (rst_n low, synchronous) empties the queue: head and occupancy cleared.
// Slot memory is not cleared; only written slots are ever read.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = DQ_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [WORD_W-1:0]   in_tdata,   // [31:0] value
  input  logic [KIND_W-1:0]   in_tuser,   // [2:0] kind
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [WORD_W-1:0]   out_tdata,  // [31:0] word
  output logic [STATUS_W-1:0] out_tuser,  // [1:0] status
  output logic                out_tlast   // final_item
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_LIST = 2'd2;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW:0]   occ_r, occ_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW:0]   rem_r, rem_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_word_r, out_word_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  logic          out_free;
  logic          acc;
  logic          full;
  logic          empty;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] ptr_inc;
  logic [AW:0]   rear_wr_sum;
  logic [AW:0]   rear_rd_sum;
  logic [AW-1:0] rear_wr;
  logic [AW-1:0] rear_rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= in_tdata;
    end
    if (mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign full      = (occ_r == DEPTH_W);
  assign empty     = (occ_r == '0);

  assign head_inc    = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
  assign head_dec    = (head_r == '0) ? LAST_IDX : head_r - AW'(1);
  assign ptr_inc     = (ptr_r == LAST_IDX) ? '0 : ptr_r + AW'(1);
  assign rear_wr_sum = {1'b0, head_r} + occ_r;
  assign rear_rd_sum = {1'b0, head_r} + occ_r - (AW + 1)'(1);
  assign rear_wr     = (rear_wr_sum >= DEPTH_W) ? AW'(rear_wr_sum - DEPTH_W)
                                                : rear_wr_sum[AW-1:0];
  assign rear_rd     = (rear_rd_sum >= DEPTH_W) ? AW'(rear_rd_sum - DEPTH_W)
                                                : rear_rd_sum[AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    occ_nxt        = occ_r;
    ptr_nxt        = ptr_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_word_nxt   = out_word_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    waddr          = head_dec;
    raddr          = head_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_tuser)
            KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '0;
              out_last_nxt  = 1'b1;
              if (full) begin
                out_status_nxt = STATUS_FULL;
              end else begin
                out_status_nxt = STATUS_OK;
                mem_we         = 1'b1;
                occ_nxt        = occ_r + (AW + 1)'(1);
                if (in_tuser == KIND_PUSH_FRONT) begin
                  waddr    = head_dec;
                  head_nxt = head_dec;
                end else begin
                  waddr = rear_wr;
                end
              end
            end
            KIND_POP_FRONT, KIND_POP_REAR: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_word_nxt   = '0;
                out_status_nxt = STATUS_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                mem_re    = 1'b1;
                occ_nxt   = occ_r - (AW + 1)'(1);
                state_nxt = ST_POP;
                if (in_tuser == KIND_POP_FRONT) begin
                  raddr    = head_r;
                  head_nxt = head_inc;
                end else begin
                  raddr = rear_rd;
                end
              end
            end
            KIND_LIST: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_word_nxt   = '0;
                out_status_nxt = STATUS_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                mem_re    = 1'b1;
                raddr     = head_r;
                ptr_nxt   = head_r;
                rem_nxt   = occ_r - (AW + 1)'(1);
                state_nxt = ST_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        out_valid_nxt  = 1'b1;
        out_word_nxt   = rd_q;
        out_status_nxt = STATUS_OK;
        out_last_nxt   = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_LIST: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = rd_q;
          out_status_nxt = STATUS_OK;
          out_last_nxt   = (rem_r == '0);
          if (rem_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            mem_re  = 1'b1;
            raddr   = ptr_inc;
            ptr_nxt = ptr_inc;
            rem_nxt = rem_r - (AW + 1)'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      ptr_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      ptr_r       <= ptr_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r   <= out_word_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

[test/tb_double_ended_queue.sv]
// Self-checking testbench for the double-ended queue: random and directed deque traffic.
`timescale 1ns / 100ps

module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int DEPTH       = DQ_DEPTH;
  localparam int HOLD_CYCLES = 120;
  localparam int WATCHDOG    = 3000;
  localparam int TAIL_CYCLES = 24;
  localparam int RANDOM_OPS  = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   word;
    logic                last;
  } dq_result_t;

  class DequeScoreboard;
    logic [WORD_W-1:0] slots [DEPTH];
    int head;
    int occ;
    dq_result_t result_q[$];
    int errors;
    int n_in;
    int n_out;
    int n_full;
    int n_empty;
    int n_list;

    function new();
      head = 0;
      occ = 0;
      errors = 0;
      n_in = 0;
      n_out = 0;
      n_full = 0;
      n_empty = 0;
      n_list = 0;
    endfunction

    function void add_result(logic [STATUS_W-1:0] status, logic [WORD_W-1:0] word,
                             logic last);
      dq_result_t r;
      r.status = status;
      r.word = word;
      r.last = last;
      result_q.push_back(r);
    endfunction

    function void note_input(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] value);
      int pos;
      n_in++;
      case (kind)
        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
          if (occ >= DEPTH) begin
            n_full++;
            add_result(STATUS_FULL, '0, 1'b1);
          end else begin
            if (kind == KIND_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              slots[head] = value;
            end else begin
              slots[(head + occ) % DEPTH] = value;
            end
            occ++;
            add_result(STATUS_OK, '0, 1'b1);
          end
        end
        KIND_POP_FRONT, KIND_POP_REAR: begin
          if (occ == 0) begin
            n_empty++;
            add_result(STATUS_EMPTY, '0, 1'b1);
          end else begin
            if (kind == KIND_POP_FRONT) begin
              pos = head;
              head = (head + 1) % DEPTH;
            end else begin
              pos = (head + occ - 1) % DEPTH;
            end
            occ--;
            add_result(STATUS_OK, slots[pos], 1'b1);
          end
        end
        KIND_LIST: begin
          n_list++;
          if (occ == 0) begin
            n_empty++;
            add_result(STATUS_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < occ; i++) begin
              add_result(STATUS_OK, slots[(head + i) % DEPTH], (i + 1 == occ));
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [WORD_W-1:0] word,
                               logic last);
      dq_result_t want;
      n_out++;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d word %h last %0b",
                 $time, status, word, last);
        return;
      end
      want = result_q.pop_front();
      if (status !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status, status);
      end
      if (word !== want.word) begin
        errors++;
        $display("%0t: word mismatch, expected %h, actual %h", $time, want.word, word);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, last);
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [WORD_W-1:0]   in_tdata;   // [31:0] value
  logic [KIND_W-1:0]   in_tuser;   // [2:0] kind
  logic                out_tvalid;
  logic                out_tready;
  logic [WORD_W-1:0]   out_tdata;  // [31:0] word
  logic [STATUS_W-1:0] out_tuser;  // [1:0] status
  logic                out_tlast;

  DequeScoreboard sb;
  bit burst;
  bit hold_req;
  int idle_cycles;

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_input(in_tuser, in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG, sb.pending());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        @(negedge clk);
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = burst ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
        @(negedge clk);
        out_tready = 1'b0;
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = value;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int mode;
    int len;
    int r;
    int push_pct;
    int counted;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_PUSH_FRONT;
    burst = 1'b0;
    hold_req = 1'b0;
    idle_cycles = 0;
    sb = new();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // empty store, extremes, wrap of the head on push front, ignored kinds
    send_item(KIND_LIST, rand_word());
    send_item(KIND_POP_FRONT, rand_word());
    send_item(KIND_POP_REAR, rand_word());
    send_item(KIND_PUSH_FRONT, 32'h8000_0000);
    send_item(KIND_PUSH_REAR, 32'h7fff_ffff);
    send_item(KIND_PUSH_FRONT, 32'hffff_ffff);
    send_item(KIND_PUSH_REAR, 32'h0000_0000);
    send_item(KIND_LIST, rand_word());
    send_item(3'd5, $urandom);
    send_item(3'd6, $urandom);
    send_item(3'd7, $urandom);
    send_item(KIND_POP_REAR, rand_word());
    send_item(KIND_POP_FRONT, rand_word());
    send_item(KIND_LIST, rand_word());
    send_item(KIND_POP_FRONT, rand_word());
    send_item(KIND_POP_REAR, rand_word());
    send_item(KIND_POP_REAR, rand_word());
    wait_drained();

    // hold the result side while pushing past full
    hold_req = 1'b1;
    burst = 1'b1;
    for (int i = 0; i < 10; i++) send_item(KIND_PUSH_FRONT, rand_word());
    for (int i = 0; i < 10; i++) send_item(KIND_PUSH_REAR, rand_word());
    send_item(KIND_PUSH_FRONT, rand_word());
    burst = 1'b0;
    send_item(KIND_LIST, rand_word());
    for (int i = 0; i < DEPTH + 1; i++) begin
      send_item((i % 2 == 0) ? KIND_POP_FRONT : KIND_POP_REAR, rand_word());
    end
    wait_drained();

    counted = 0;
    while (counted < RANDOM_OPS) begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(8, 40);
      burst = ($urandom_range(0, 4) == 0);
      push_pct = (mode == 0) ? 65 : (mode == 1) ? 25 : 45;
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_item(3'($urandom_range(5, 7)), $urandom);
        end else begin
          counted++;
          if (r < 11) begin
            send_item(KIND_LIST, rand_word());
          end else if (r < 11 + push_pct) begin
            send_item($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR, rand_word());
          end else begin
            send_item($urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_REAR, rand_word());
          end
        end
      end
      burst = 1'b0;
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d items and %0d results, %0d listings", sb.n_in, sb.n_out, sb.n_list);
    $display("%0d refused pushes, %0d empty or underflow results", sb.n_full, sb.n_empty);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/dq_pkg.sv
src/double_ended_queue.sv
test/tb_double_ended_queue.sv
